// File: sv/mosa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mosa_pkg
// shared sizes, controller state type, command/status bundles and the
// truncating mean used by the median datapath
// ----------------------------------------------------------------------------
package mosa_pkg;

    localparam int MAX_LEN = 1024;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_ADDR0,
        S_ADDR1,
        S_WAIT,
        S_REDUCE,
        S_DECIDE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // word accepted, store it
        logic start;       // word was the last one, open the windows
        logic rd_sel;      // 0: first read offset, 1: second read offset
        logic lat0;        // capture first read data
        logic lat1;        // capture second read data
        logic reduce;      // form the two window values
        logic step;        // narrow the windows
        logic set_result;  // load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic finish;      // windows small enough or medians equal
    } t_dp_sts;

    // (a + b) / 2 over a 33-bit sum, truncated toward zero
    function automatic logic signed [DATA_W-1:0] f_mean(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W]) begin
            s = s + (DATA_W+1)'(1);
        end
        return s[DATA_W:1];
    endfunction

endpackage
`default_nettype wire

// File: sv/mosa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mosa_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mosa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/mosa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mosa_ctrl
// sequencer for loading, window narrowing passes and result handoff
// ----------------------------------------------------------------------------
module mosa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire mosa_pkg::t_dp_sts i_sts,
    output mosa_pkg::t_dp_cmd      o_cmd
);
    import mosa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_ADDR0;
                    end
                end
            end
            S_ADDR0: begin
                n_state = S_ADDR1;
            end
            S_ADDR1: begin
                o_cmd.rd_sel = 1'b1;
                o_cmd.lat0   = 1'b1;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.lat1 = 1'b1;
                n_state    = S_REDUCE;
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.finish) begin
                    // hold until the previous word has left
                    if (!r_out_valid) begin
                        o_cmd.set_result = 1'b1;
                        n_state          = S_LOAD;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_ADDR0;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.set_result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: sv/mosa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mosa_dp
// element stores, window bases and length, median compare and result register
// ----------------------------------------------------------------------------
module mosa_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mosa_pkg::t_dp_cmd                   i_cmd,
    input  wire logic signed [mosa_pkg::DATA_W-1:0]  i_a_value,
    input  wire logic signed [mosa_pkg::DATA_W-1:0]  i_b_value,
    output mosa_pkg::t_dp_sts                        o_sts,
    output logic signed      [mosa_pkg::DATA_W-1:0]  o_median
);
    import mosa_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_len;
    logic [IDX_W-1:0]         r_xb;
    logic [IDX_W-1:0]         r_yb;
    logic                     r_swap;
    logic signed [DATA_W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [DATA_W-1:0] r_ma, r_mb;
    logic signed [DATA_W-1:0] r_median;

    logic                     room;
    logic [CNT_W-1:0]         n_len;
    logic [CNT_W+1:0]         len_x;
    logic                     short_win;
    logic                     is_two;
    logic                     even;
    logic [CNT_W-1:0]         half;
    logic [CNT_W-1:0]         off;
    logic [CNT_W-1:0]         skip;
    logic [CNT_W-1:0]         nlen;
    logic [IDX_W-1:0]         px, py;
    logic [IDX_W-1:0]         raddr0, raddr1;
    logic [DATA_W-1:0]        rdata0, rdata1;
    logic signed [DATA_W-1:0] xd, yd;
    logic                     we;

    assign room   = (r_count < CNT_W'(MAX_LEN));
    assign we     = i_cmd.load && room;
    assign n_len  = room ? (r_count + CNT_W'(1)) : CNT_W'(MAX_LEN);

    assign len_x     = (CNT_W+2)'(r_len);
    assign short_win = (len_x <= (CNT_W+2)'(2));
    assign is_two    = (len_x == (CNT_W+2)'(2));
    assign even   = !r_len[0];
    assign half   = r_len >> 1;
    assign skip   = even ? (half - CNT_W'(1)) : half;
    assign nlen   = even ? (r_len - half + CNT_W'(1)) : (r_len - half);

    // first read: middle (or window head), second read: lower middle (or next)
    always_comb begin
        if (short_win) begin
            off = i_cmd.rd_sel ? CNT_W'(1) : CNT_W'(0);
        end else begin
            off = i_cmd.rd_sel ? (half - CNT_W'(1)) : half;
        end
    end

    assign px     = IDX_W'(CNT_W'(r_xb) + off);
    assign py     = IDX_W'(CNT_W'(r_yb) + off);
    assign raddr0 = r_swap ? py : px;
    assign raddr1 = r_swap ? px : py;
    assign xd     = r_swap ? $signed(rdata1) : $signed(rdata0);
    assign yd     = r_swap ? $signed(rdata0) : $signed(rdata1);

    mosa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN),
        .AW    (IDX_W)
    ) u_first_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_a_value),
        .i_raddr (raddr0),
        .o_rdata (rdata0)
    );

    mosa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN),
        .AW    (IDX_W)
    ) u_second_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_b_value),
        .i_raddr (raddr1),
        .o_rdata (rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_xb    <= '0;
            r_yb    <= '0;
            r_swap  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_count <= '0;
                r_len   <= n_len;
                r_xb    <= '0;
                r_yb    <= '0;
                r_swap  <= 1'b0;
            end else if (we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.step) begin
                r_len <= nlen;
                if (r_ma < r_mb) begin
                    r_xb <= IDX_W'(CNT_W'(r_xb) + skip);
                end else begin
                    r_swap <= !r_swap;
                    r_xb   <= IDX_W'(CNT_W'(r_yb) + skip);
                    r_yb   <= r_xb;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat0) begin
            r_x0 <= xd;
            r_y0 <= yd;
        end
        if (i_cmd.lat1) begin
            r_x1 <= xd;
            r_y1 <= yd;
        end
        if (i_cmd.reduce) begin
            if (is_two) begin
                r_ma <= (r_x0 > r_y0) ? r_x0 : r_y0;
                r_mb <= (r_y1 > r_x1) ? r_x1 : r_y1;
            end else if (even) begin
                r_ma <= f_mean(r_x0, r_x1);
                r_mb <= f_mean(r_y0, r_y1);
            end else begin
                r_ma <= r_x0;
                r_mb <= r_y0;
            end
        end
        if (i_cmd.set_result) begin
            r_median <= short_win ? f_mean(r_ma, r_mb) : r_ma;
        end
    end

    assign o_sts.finish = short_win || (r_ma == r_mb);
    assign o_median     = r_median;

endmodule
`default_nettype wire

// File: sv/median_of_two_sorted_arrays_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays_unit
// median of two equal-length sorted arrays, loaded one element pair per word
// ----------------------------------------------------------------------------
// usage
//   input channel: each word carries one element of each array at the same
//   position; i_last marks the final pair. the unit takes one word per cycle
//   while loading. pairs beyond MAX_LEN are dropped, length saturates.
//   after the last word the input is stalled while the search runs. each
//   narrowing pass steps through two ram reads, read latency, reduce and
//   decide, the two reads due to the single read port of each store. n
//   pairs need ceil(log2(n - 1)) + 1 passes (one for n = 1), fewer once
//   the window medians match; the final pass loads the result word into
//   the output register. even-length medians truncate toward zero.
//   output channel: one word per last pair, held in an output register.
//   loading of the next run proceeds while that word waits; a finished
//   search waits in its decide step if the previous word is still stalled.
//   reset: synchronous, active low. the stores are not cleared; every read
//   whose data is used falls on an entry written in the current run.
// ----------------------------------------------------------------------------
module median_of_two_sorted_arrays_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [mosa_pkg::DATA_W-1:0] i_a_value,
    input  wire logic signed [mosa_pkg::DATA_W-1:0] i_b_value,
    input  wire logic                               i_last,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed      [mosa_pkg::DATA_W-1:0] o_median
);
    import mosa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: owns the handshakes and the pass schedule
    mosa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, window registers and compare logic
    mosa_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_a_value (i_a_value),
        .i_b_value (i_b_value),
        .o_sts     (sts),
        .o_median  (o_median)
    );

`ifndef SYNTHESIS
    // a last word starts the search, so the input must stall next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last) |=> o_in_stall)
        else $error("input not stalled after last word");

    // a new result never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.set_result |-> !o_out_valid)
        else $error("result written over pending word");

    // a finished search shows up at the output next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.set_result |=> o_out_valid)
        else $error("result not presented");

    // start, narrowing and finish are mutually exclusive commands
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.step, cmd.set_result}))
        else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for median_of_two_sorted_arrays_unit: element pairs are
// queued as runs, driven with random gaps, and every median coming out is
// compared against a predictor of the windowed halving search
// ----------------------------------------------------------------------------
module tb;

    import mosa_pkg::*;

    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
    // settle time after the last median, well over the longest search
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 625;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic                     last;
    } t_word;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_a_value;
    logic signed [DATA_W-1:0] i_b_value;
    logic                     i_last;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_median;

    // words waiting to be driven, and medians waiting to come out
    t_word                    words_todo[$];
    logic signed [DATA_W-1:0] medians_due[$];

    // predictor copy of the two stores and the fill count
    logic signed [DATA_W-1:0] first_mem [MAX_LEN];
    logic signed [DATA_W-1:0] second_mem[MAX_LEN];
    int                       pairs_loaded;

    int    mismatches;
    int    words_taken;
    int    medians_checked;
    int    longest_run;

    // driver and receiver pacing
    t_word nxt_word;
    bit    in_took;
    int    in_gap;
    bit    in_calm;
    int    out_wait;
    bit    out_calm;

    median_of_two_sorted_arrays_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_a_value   (i_a_value),
        .i_b_value   (i_b_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_median    (o_median)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // store read, out-of-range entries read as zero
    function automatic longint store_rd(input bit sel, input int unsigned idx);
        if (idx >= MAX_LEN) begin
            return 0;
        end
        return sel ? longint'(second_mem[idx]) : longint'(first_mem[idx]);
    endfunction

    // mean over a wide sum, longint division truncates toward zero
    function automatic longint half_sum(input longint x, input longint y);
        return (x + y) / 2;
    endfunction

    function automatic longint window_mid(input bit sel, input int unsigned base,
                                          input int unsigned len);
        int unsigned h;
        h = len / 2;
        if (len % 2 == 0) begin
            return half_sum(store_rd(sel, base + h), store_rd(sel, base + h - 1));
        end
        return store_rd(sel, base + h);
    endfunction

    // windowed halving over the stored pairs; the window holding the smaller
    // median keeps its upper part and becomes the first window
    function automatic logic signed [DATA_W-1:0] combined_median(input int unsigned n);
        bit          xsel;
        bit          ysel;
        bit          tsel;
        bit          done;
        int unsigned xb;
        int unsigned yb;
        int unsigned tb_base;
        int unsigned len;
        int unsigned h;
        int unsigned skip;
        int unsigned nlen;
        longint      m1;
        longint      m2;
        longint      hi;
        longint      lo;
        longint      res;
        xsel = 1'b0;
        ysel = 1'b1;
        xb   = 0;
        yb   = 0;
        len  = n;
        done = 1'b0;
        res  = 0;
        while (!done) begin
            if (len == 0) begin
                res  = -1;
                done = 1'b1;
            end else if (len == 1) begin
                res  = half_sum(store_rd(xsel, xb), store_rd(ysel, yb));
                done = 1'b1;
            end else if (len == 2) begin
                // larger of the lower pair, smaller of the upper pair
                hi = store_rd(xsel, xb) > store_rd(ysel, yb) ?
                     store_rd(xsel, xb) : store_rd(ysel, yb);
                lo = store_rd(ysel, yb + 1) > store_rd(xsel, xb + 1) ?
                     store_rd(xsel, xb + 1) : store_rd(ysel, yb + 1);
                res  = half_sum(hi, lo);
                done = 1'b1;
            end else begin
                m1   = window_mid(xsel, xb, len);
                m2   = window_mid(ysel, yb, len);
                h    = len / 2;
                skip = (len % 2 == 0) ? h - 1 : h;
                nlen = (len % 2 == 0) ? len - h + 1 : len - h;
                if (m1 == m2) begin
                    res  = m1;
                    done = 1'b1;
                end else if (m1 < m2) begin
                    xb = xb + skip;
                end else begin
                    tsel    = xsel;
                    xsel    = ysel;
                    ysel    = tsel;
                    tb_base = xb;
                    xb      = yb + skip;
                    yb      = tb_base;
                end
                len = nlen;
            end
        end
        return res[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------

    task automatic add_run(input int av[$], input int bv[$]);
        t_word w;
        foreach (av[i]) begin
            w.a    = av[i];
            w.b    = bv[i];
            w.last = (i == av.size() - 1);
            words_todo.push_back(w);
        end
    endtask

    // ascending values, step size picked per array so that duplicates,
    // dense and sparse data and clamping at the top all show up
    task automatic fill_sorted(output int vals[$], input int n);
        longint      v;
        int unsigned span;
        vals = {};
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 3;
            2:       span = 65536;
            default: span = 1 << 29;
        endcase
        v = ($urandom_range(0, 3) == 0) ? longint'(VMIN) : longint'($signed($urandom()));
        for (int i = 0; i < n; i++) begin
            vals.push_back(int'(v));
            v = v + $urandom_range(0, span);
            if (v > longint'(VMAX)) begin
                v = VMAX;
            end
        end
    endtask

    task automatic gen_run(input int n);
        int av[$];
        int bv[$];
        int style;
        style = $urandom_range(0, 9);
        if (style < 2) begin
            // unsorted noise
            for (int i = 0; i < n; i++) begin
                av.push_back($urandom());
                bv.push_back($urandom());
            end
        end else begin
            fill_sorted(av, n);
            if (style == 2) begin
                // identical arrays, window medians agree on the first pass
                bv = av;
            end else begin
                fill_sorted(bv, n);
            end
        end
        add_run(av, bv);
    endtask

    // ------------------------------------------------------------------------
    // input driver: one word presented at a time, held until taken, then a
    // random gap before the next one
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                in_took = 1'b0;
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (words_todo.size() > 0) begin
                    nxt_word = words_todo.pop_front();
                    i_a_value  <= nxt_word.a;
                    i_b_value  <= nxt_word.b;
                    i_last     <= nxt_word.last;
                    i_in_valid <= 1'b1;
                    in_gap = in_calm ? 0 : $urandom_range(0, 11);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output receiver: holds off each median for a random number of cycles,
    // toggles stall at random while nothing is offered
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else if (o_out_valid === 1'b1) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= !out_calm && ($urandom_range(0, 3) == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check medians leaving, predict for words entering
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // median taken by the receiver
            if (o_out_valid && !i_out_stall) begin
                if (medians_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected median %0d", o_median));
                end else begin
                    if (o_median !== medians_due[0]) begin
                        report_mismatch($sformatf("median got %0d expected %0d",
                                                  o_median, medians_due[0]));
                    end
                    void'(medians_due.pop_front());
                end
                medians_checked++;
                out_wait = out_calm ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 19) == 0) begin
                    out_calm = !out_calm;
                end
            end
            // word taken by the unit, pairs past the store size are dropped
            if (i_in_valid && !o_in_stall) begin
                in_took = 1'b1;
                words_taken++;
                if (pairs_loaded < MAX_LEN) begin
                    first_mem[pairs_loaded]  = i_a_value;
                    second_mem[pairs_loaded] = i_b_value;
                    pairs_loaded++;
                end
                if (i_last) begin
                    medians_due.push_back(combined_median(pairs_loaded));
                    if (pairs_loaded > longest_run) begin
                        longest_run = pairs_loaded;
                    end
                    pairs_loaded = 0;
                end
                if ($urandom_range(0, 39) == 0) begin
                    in_calm = !in_calm;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int da[$];
        int db[$];
        int queued;
        int r;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_a_value    = '0;
        i_b_value    = '0;
        i_last       = 1'b0;
        i_out_stall  = 1'b0;
        pairs_loaded = 0;
        mismatches   = 0;
        words_taken  = 0;
        medians_checked = 0;
        longest_run  = 0;
        in_took      = 1'b0;
        in_gap       = 0;
        in_calm      = 1'b0;
        out_wait     = $urandom_range(0, 11);
        out_calm     = 1'b0;

        // directed: single pairs at the extremes and odd negative sums
        da = '{VMAX};           db = '{VMAX};           add_run(da, db);
        da = '{VMIN};           db = '{VMIN};           add_run(da, db);
        da = '{-3};             db = '{0};              add_run(da, db);
        da = '{VMAX};           db = '{VMIN};           add_run(da, db);
        // two-element windows
        da = '{1, 5};           db = '{2, 3};           add_run(da, db);
        // equal window medians, odd and even length
        da = '{-7, 4, 9};       db = '{-7, 4, 9};       add_run(da, db);
        da = '{0, 2, 4, 6};     db = '{1, 2, 4, 5};     add_run(da, db);
        // unsorted data
        da = '{9, -2, 5};       db = '{0, 7, -8};       add_run(da, db);
        // first median larger, windows swap
        da = '{10, 20, 30, 40, 50}; db = '{1, 2, 3, 4, 5}; add_run(da, db);
        // first median smaller, even length
        da = '{-10, -5, 0, 5};  db = '{100, 200, 300, 400}; add_run(da, db);

        // random runs, mostly short, last one trimmed to the word budget
        queued = 0;
        while (queued < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                r = $urandom_range(1, 8);
            end else if (r < 95) begin
                r = $urandom_range(9, 40);
            end else begin
                r = $urandom_range(41, 200);
            end
            if (r > RANDOM_WORDS - queued) begin
                r = RANDOM_WORDS - queued;
            end
            gen_run(r);
            queued += r;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_todo.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (medians_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d medians out, longest run %0d pairs",
                 words_taken, medians_checked, longest_run);
        $display("includes extremes, equal medians, swapped windows and unsorted runs");
        if (mismatches == 0) begin
            $display("median_of_two_sorted_arrays_unit regression: pass");
        end else begin
            $display("median_of_two_sorted_arrays_unit regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d medians still due", medians_due.size());
        $display("median_of_two_sorted_arrays_unit regression: fail");
        $finish;
    end

endmodule

// File: median_of_two_sorted_arrays_unit.f
sv/mosa_pkg.sv
sv/mosa_ram.sv
sv/mosa_ctrl.sv
sv/mosa_dp.sv
sv/median_of_two_sorted_arrays_unit.sv
verif/tb.sv
